// ===== rtl/fota_pkg.sv =====
// Shared types and constants for the frequency ordered address table.
package fota_pkg;

  localparam int DEF_CAPACITY = 256;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_READ_OK  = 3'd3;
  localparam logic [2:0] ST_READ_BAD = 3'd4;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] address;
    logic [7:0]  read_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [63:0] entry_address;
    logic [63:0] entry_count;
    logic [8:0]  used_entries;
  } rsp_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] cnt;
  } entry_t;

endpackage

// ===== rtl/frequency_ordered_address_table_unit.sv =====
// Frequency ordered address table: a count-and-transpose list held in one memory.
// From accept to rsp_valid: a record miss scans the used slots, one slot scanned per cycle,
// then inserts or drops; a hit in the top used slot goes to S_EMIT, any other passes S_NB
// and, on a swap, S_SW2; a read passes S_RD, or goes straight to S_EMIT for an unused slot.
// One beat at a time: the next is taken once the unit is back in S_IDLE, after the result is registered in S_EMIT.
// rst is synchronous, active high: it empties the table at once and drops any pending beat.
module frequency_ordered_address_table_unit #(
  parameter int CAPACITY = fota_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fota_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fota_pkg::rsp_t rsp
);
  import fota_pkg::*;

  // Slot index width and entry-count width (the count can reach CAPACITY itself).
  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_NB,
    S_SW2,
    S_RD,
    S_EMIT
  } state_t;

  state_t        state;
  logic [CW-1:0] total;
  logic [CW-1:0] scan;
  logic          pend;
  logic [SW-1:0] pend_idx;
  logic [SW-1:0] hit_k;
  logic [63:0]   addr_q;
  logic [63:0]   cur_cnt;
  logic [7:0]    slot_q;
  rsp_t          res;

  // Table memory: one write and one registered read per cycle.
  entry_t        mem [CAPACITY];
  entry_t        rd_data;
  logic [SW-1:0] rd_idx;
  logic          wr_en;
  logic [SW-1:0] wr_idx;
  entry_t        wr_data;

  logic [CW-1:0] k_next;
  logic          hit;
  logic          swap;
  logic [63:0]   inc_cnt;
  logic          rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

  // The scan is pipelined: while slot i is read, the data of slot i-1 is compared.
  assign k_next  = CW'(pend_idx) + CW'(1);
  assign hit     = pend && (rd_data.addr == addr_q);
  assign inc_cnt = rd_data.cnt + 64'd1;
  // The hit entry trades places only with a strictly smaller higher neighbor.
  assign swap    = rd_data.cnt < cur_cnt;
  assign rd_ok   = (XW'(req.read_slot) < XW'(total)) && (XW'(req.read_slot) < XW'(CAPACITY));

  assign req_stall = (state != S_IDLE);

  always_comb begin
    rd_idx  = '0;
    wr_en   = 1'b0;
    wr_idx  = hit_k;
    wr_data = entry_t'{addr: addr_q, cnt: cur_cnt};
    case (state)
      S_IDLE: begin
        rd_idx = SW'(req.read_slot);
      end
      S_SCAN: begin
        if (hit) begin
          rd_idx = k_next[SW-1:0];
          if (!(k_next < total)) begin
            wr_en   = 1'b1;
            wr_idx  = pend_idx;
            wr_data = entry_t'{addr: addr_q, cnt: inc_cnt};
          end
        end else if (scan < total) begin
          rd_idx = scan[SW-1:0];
        end else if (total < CW'(CAPACITY)) begin
          wr_en   = 1'b1;
          wr_idx  = total[SW-1:0];
          wr_data = entry_t'{addr: addr_q, cnt: 64'd1};
        end
      end
      S_NB: begin
        wr_en   = 1'b1;
        wr_idx  = hit_k;
        wr_data = swap ? rd_data : entry_t'{addr: addr_q, cnt: cur_cnt};
      end
      S_SW2: begin
        wr_en   = 1'b1;
        wr_idx  = hit_k + SW'(1);
        wr_data = entry_t'{addr: addr_q, cnt: cur_cnt};
      end
      default: begin
      end
    endcase
  end

  // Sequencer, result assembly and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      scan      <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            addr_q <= req.address;
            slot_q <= req.read_slot;
            scan   <= '0;
            pend   <= 1'b0;
            if (req.req_type == REQ_RECORD) begin
              state <= S_SCAN;
            end else if (rd_ok) begin
              state <= S_RD;
            end else begin
              res   <= '{status: ST_READ_BAD, slot: req.read_slot, entry_address: 64'd0,
                         entry_count: 64'd0, used_entries: 9'(total)};
              state <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            hit_k   <= pend_idx;
            cur_cnt <= inc_cnt;
            if (k_next < total) begin
              state <= S_NB;
            end else begin
              res   <= '{status: ST_HIT, slot: 8'(pend_idx), entry_address: addr_q,
                         entry_count: inc_cnt, used_entries: 9'(total)};
              state <= S_EMIT;
            end
          end else if (scan < total) begin
            pend     <= 1'b1;
            pend_idx <= scan[SW-1:0];
            scan     <= scan + CW'(1);
          end else if (total < CW'(CAPACITY)) begin
            total <= total + CW'(1);
            res   <= '{status: ST_INSERTED, slot: 8'(total), entry_address: addr_q,
                       entry_count: 64'd1, used_entries: 9'(total + CW'(1))};
            state <= S_EMIT;
          end else begin
            res   <= '{status: ST_DROPPED, slot: 8'd0, entry_address: 64'd0,
                       entry_count: 64'd0, used_entries: 9'(total)};
            state <= S_EMIT;
          end
        end
        S_NB: begin
          if (swap) begin
            state <= S_SW2;
          end else begin
            res   <= '{status: ST_HIT, slot: 8'(hit_k), entry_address: addr_q,
                       entry_count: cur_cnt, used_entries: 9'(total)};
            state <= S_EMIT;
          end
        end
        S_SW2: begin
          res   <= '{status: ST_HIT, slot: 8'(hit_k + SW'(1)), entry_address: addr_q,
                     entry_count: cur_cnt, used_entries: 9'(total)};
          state <= S_EMIT;
        end
        S_RD: begin
          res   <= '{status: ST_READ_OK, slot: slot_q, entry_address: rd_data.addr,
                     entry_count: rd_data.cnt, used_entries: 9'(total)};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more entries than it has slots.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(CAPACITY))
    else $error("entry total exceeds capacity");

  // A slot under comparison during the scan is always a used slot.
  a_pend_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pend) |-> (CW'(pend_idx) < total))
    else $error("scan compares an unused slot");

  // The scan pointer never runs past the used entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan <= total))
    else $error("scan pointer beyond used entries");

  // An insertion grows the table by exactly one entry.
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !hit && !(scan < total) && total < CW'(CAPACITY))
      |=> (total == $past(total) + CW'(1)))
    else $error("insertion did not grow the table by one");

endmodule
